### design/jid_esc_pkg.sv
// Shared types, constants and character helpers for the JID node escaper.
package jid_esc_pkg;

  localparam int MaxOut = 9;
  localparam int CntW   = $clog2(MaxOut + 1);
  localparam int IdxW   = $clog2(MaxOut);

  localparam logic [7:0] BSLASH = 8'h5C;

  // One item's worth of escaped bytes, packed from slot 0 upward
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
    logic                   last;
  } burst_t;

  // Pending window status seen by the top level
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] head;
  } pend_t;

  // Hex digit decode: valid flag and nibble
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_special(input logic [7:0] b);
    unique case (b)
      8'h20, 8'h22, 8'h26, 8'h27, 8'h2F, 8'h3C, 8'h3E, 8'h40, 8'h3A: is_special = 1'b1;
      default: is_special = 1'b0;
    endcase
  endfunction

  function automatic hex_t hex_val(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end else begin
      return 8'h57 + {4'h0, n};
    end
  endfunction

endpackage

### design/jid_esc_window.sv
// Pending-byte window and single-pass escape decision for one input word.
module jid_esc_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_string,
  output jid_esc_pkg::burst_t burst,
  output jid_esc_pkg::pend_t  status
);
  import jid_esc_pkg::*;

  logic [1:0][7:0] pend_bytes;
  logic [1:0]      pend_count;
  logic [1:0][7:0] pend_bytes_next;
  logic [1:0]      pend_count_next;

  logic [2:0][7:0] win;
  logic [1:0]      len;
  logic            bs_esc;
  hex_t            h1;
  hex_t            h2;

  // Build the window: pending bytes followed by the new byte
  always_comb begin
    len    = pend_count + 2'd1;
    win[0] = (pend_count == 2'd0) ? in_byte : pend_bytes[0];
    win[1] = (pend_count == 2'd1) ? in_byte : pend_bytes[1];
    win[2] = in_byte;
    h1     = hex_val(win[1]);
    h2     = hex_val(win[2]);
    bs_esc = h1.ok && h2.ok &&
             ({h1.val, h2.val} == BSLASH || is_special({h1.val, h2.val}));
  end

  // Walk the window, emitting bytes until a backslash must wait
  always_comb begin
    logic            running;
    logic            found;
    logic [1:0]      stop_pos;
    logic [1:0]      left;
    logic            esc;
    logic [CntW-1:0] n;
    logic [1:0]      k;
    running         = 1'b1;
    found           = 1'b0;
    stop_pos        = 2'd0;
    left            = 2'd0;
    esc             = 1'b0;
    n               = '0;
    k               = 2'd0;
    burst.bytes     = '0;
    pend_bytes_next = pend_bytes;
    for (int i = 0; i < 3; i++) begin
      if (running && 2'(i) < len) begin
        left = len - 2'(i);
        esc  = 1'b0;
        if (win[i] == BSLASH) begin
          if (left == 2'd3) begin
            esc = bs_esc;
          end else if (!end_of_string) begin
            running  = 1'b0;
            found    = 1'b1;
            stop_pos = 2'(i);
          end
        end else begin
          esc = is_special(win[i]);
        end
        if (running) begin
          if (esc) begin
            burst.bytes[IdxW'(n)]              = BSLASH;
            burst.bytes[IdxW'(n + CntW'(1))]   = hex_lower(win[i][7:4]);
            burst.bytes[IdxW'(n + CntW'(2))]   = hex_lower(win[i][3:0]);
            n = n + CntW'(3);
          end else begin
            burst.bytes[IdxW'(n)] = win[i];
            n = n + CntW'(1);
          end
        end
      end
    end
    burst.count = n;
    burst.last  = end_of_string;
    // Undecided tail carries to the next word
    if (!end_of_string && found) begin
      k = len - stop_pos;
      pend_bytes_next[0] = win[stop_pos];
      if (k == 2'd2) begin
        pend_bytes_next[1] = win[stop_pos + 2'd1];
      end
    end
    pend_count_next = k;
  end

  // Pending count is control state; pending bytes need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
    end else if (accept) begin
      pend_count <= pend_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bytes <= pend_bytes_next;
    end
  end

  assign status.count = pend_count;
  assign status.head  = pend_bytes[0];

endmodule

### design/jid_esc_outbuf.sv
// Result register bank that drains one escaped byte per word handshake.
module jid_esc_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  jid_esc_pkg::burst_t burst,
  output logic                load_ok,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_valid,
  input  logic                out_stall
);
  import jid_esc_pkg::*;

  logic [MaxOut-1:0][7:0] data;
  logic [CntW-1:0]        count;
  logic [CntW-1:0]        rd;
  logic                   last_flag;
  logic                   final_byte;

  assign out_valid  = (rd != count);
  assign final_byte = (rd == count - CntW'(1));
  assign load_ok    = !out_valid || (final_byte && !out_stall);
  assign out_byte   = data[IdxW'(rd)];
  assign out_last   = last_flag && final_byte;

  // Read pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd        <= '0;
      last_flag <= 1'b0;
    end else if (load) begin
      count     <= burst.count;
      rd        <= '0;
      last_flag <= burst.last;
    end else if (out_valid && !out_stall) begin
      rd <= rd + CntW'(1);
    end
  end

  // Byte slots
  always_ff @(posedge clk) begin
    if (load) begin
      data <= burst.bytes;
    end
  end

endmodule

### design/jid_node_escaper_unit.sv
// Top level of the streaming JID node escaper.
// Each accepted word is one raw byte of a node string; the escaped bytes come out one
// per output word, the final one flagged by out_last. An input word is taken in the
// cycle the result bank passes out its last byte (or is empty), so the unit sustains
// one input word per cycle while bytes pass unchanged and the output does not stall;
// an escaped character, or a word that releases a held backslash plus two special
// followers, holds the input until its bytes drain through the single output port of
// the result bank. A backslash and the byte after it may be held back (no output)
// until the next word decides them; the string's final word flushes everything.
module jid_node_escaper_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import jid_esc_pkg::*;

  burst_t burst;
  pend_t  status;
  logic   load_ok;
  logic   accept;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  // Escape decision and pending window
  jid_esc_window u_window (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .burst         (burst),
    .status        (status)
  );

  // Result bank
  jid_esc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .load_ok   (load_ok),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // Checks
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> status.count == 2'd0)
    else $error("pending window not emptied at string end");

  a_flush_emits: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> out_valid)
    else $error("string end produced no output");

  a_pend_head: assert property (@(posedge clk) disable iff (rst)
    status.count != 2'd0 |-> status.head == BSLASH)
    else $error("pending window does not start with a backslash");

  a_pend_depth: assert property (@(posedge clk) disable iff (rst)
    status.count != 2'd3)
    else $error("pending window overfilled");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result bank");

endmodule

### tb/jid_node_escaper_unit_tb.sv
// Self-checking testbench for the streaming JID node escaper.
module jid_node_escaper_unit_tb;
  import jid_esc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  // Escaped words still owed by the unit, oldest first
  esc_word_t  esc_due[$];
  // Predictor copy of the undecided window
  logic [7:0] held_bytes[2];
  int         held_count = 0;

  int snd_idle = 0;
  int rcv_idle = 0;
  int err_count = 0;

  jid_node_escaper_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(12 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---- predictor ----

  function automatic bit char_needs_escape(input logic [7:0] c);
    case (c)
      8'h20, 8'h22, 8'h26, 8'h27, 8'h2F, 8'h3C, 8'h3E, 8'h40, 8'h3A: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Nibble value of a hex digit of either case, -1 if not a digit
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] digit_of(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (upper ? 8'h37 : 8'h57) + {4'h0, n};
  endfunction

  function automatic void owe_plain(input logic [7:0] c);
    esc_due.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void owe_escape(input logic [7:0] c);
    owe_plain(BSLASH);
    owe_plain(digit_of(c[7:4], 1'b0));
    owe_plain(digit_of(c[3:0], 1'b0));
  endfunction

  // Works out the escaped words caused by one accepted input word
  function automatic void predict_escape(input logic [7:0] c, input logic eos);
    logic [7:0] win[3];
    int         len;
    int         pos;
    int         hi;
    int         lo;
    int         start;
    int         k;
    logic [7:0] v;
    start = esc_due.size();
    len = held_count;
    if (len > 0) win[0] = held_bytes[0];
    if (len > 1) win[1] = held_bytes[1];
    win[len] = c;
    len++;
    pos = 0;
    while (pos < len) begin
      if (win[pos] == BSLASH && len - pos < 3) begin
        // short tail: wait for more, or pass at string end
        if (!eos) break;
        owe_plain(win[pos]);
      end else if (win[pos] == BSLASH) begin
        hi = nibble_of(win[pos+1]);
        lo = nibble_of(win[pos+2]);
        v  = 8'((hi << 4) | lo);
        if (hi >= 0 && lo >= 0 && (v == BSLASH || char_needs_escape(v))) begin
          owe_escape(win[pos]);
        end else begin
          owe_plain(win[pos]);
        end
      end else if (char_needs_escape(win[pos])) begin
        owe_escape(win[pos]);
      end else begin
        owe_plain(win[pos]);
      end
      pos++;
    end
    if (eos) begin
      held_count = 0;
      if (esc_due.size() > start) esc_due[esc_due.size()-1].last = 1'b1;
    end else begin
      k = len - pos;
      if (k > 0) held_bytes[0] = win[pos];
      if (k > 1) held_bytes[1] = win[pos+1];
      held_count = k;
    end
  endfunction

  // ---- receiver: random stall and result check ----
  always @(posedge clk) begin
    esc_word_t want;
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
    if (!rst && out_valid && !out_stall) begin
      if (esc_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: byte %02h last %0b", out_byte, out_last);
      end else begin
        want = esc_due.pop_front();
        if (out_byte !== want.ch || out_last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     want.ch, want.last, out_byte, out_last);
        end
      end
    end
  end

  // ---- sender ----

  // Presents one word after random idle cycles; returns at the accepting edge
  task automatic send_word(input logic [7:0] c, input logic eos);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= c;
    end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_escape(c, eos);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
  endtask

  // Hold the input off until every owed word is out, then let the unit settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (esc_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // ---- tests ----

  task automatic test_plain_bytes();
    send_string({8'h00});
    send_string({8'hFF, 8'h7F, 8'h80});
  endtask

  task automatic test_special_chars();
    send_string({8'h20, 8'h22, 8'h26, 8'h27, 8'h2F, 8'h3C, 8'h3E, 8'h40, 8'h3A});
  endtask

  // Overlapping backslashes, upper-case digits, and a non-hex follower
  task automatic test_backslash_rules();
    send_string({BSLASH, BSLASH, "3", "a"});
    send_string({BSLASH, "5", "C", BSLASH, "4", "x"});
  endtask

  // Backslash with fewer than two bytes behind it at string end
  task automatic test_short_tails();
    send_string({BSLASH});
    send_string({BSLASH, "4"});
  endtask

  // Strings biased toward escape sequences, mixed with noise
  task automatic test_random_strings(input int n_words);
    logic [7:0] s[$];
    logic [7:0] v;
    int         sent;
    int         len;
    sent = 0;
    while (sent < n_words) begin
      s.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      while (s.size() < len) begin
        case ($urandom_range(0, 9))
          0, 1, 2: s.push_back(8'($urandom_range(0, 255)));
          3, 4: begin
            case ($urandom_range(0, 8))
              0: v = 8'h20; 1: v = 8'h22; 2: v = 8'h26;
              3: v = 8'h27; 4: v = 8'h2F; 5: v = 8'h3C;
              6: v = 8'h3E; 7: v = 8'h40; default: v = 8'h3A;
            endcase
            s.push_back(v);
          end
          5, 6: begin
            // encoded sequence: mostly a special value or 5C, sometimes any value
            case ($urandom_range(0, 10))
              0: v = 8'h20; 1: v = 8'h22; 2: v = 8'h26;
              3: v = 8'h27; 4: v = 8'h2F; 5: v = 8'h3C;
              6: v = 8'h3E; 7: v = 8'h40; 8: v = 8'h3A;
              9: v = BSLASH;
              default: v = 8'($urandom_range(0, 255));
            endcase
            s.push_back(BSLASH);
            s.push_back(digit_of(v[7:4], 1'($urandom_range(0, 1))));
            s.push_back(digit_of(v[3:0], 1'($urandom_range(0, 1))));
          end
          7: s.push_back(BSLASH);
          default: s.push_back(digit_of(4'($urandom_range(0, 15)),
                                        1'($urandom_range(0, 1))));
        endcase
      end
      send_string(s);
      sent += s.size();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    snd_idle = 23;
    rcv_idle = 87;
    test_plain_bytes();
    test_special_chars();
    test_backslash_rules();
    test_short_tails();
    test_random_strings(75);
    drain_results();

    snd_idle = 87;
    rcv_idle = 23;
    test_random_strings(75);
    drain_results();

    snd_idle = 0;
    rcv_idle = 0;
    test_random_strings(70);
    drain_results();

    if (esc_due.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
design/jid_esc_pkg.sv
design/jid_esc_window.sv
design/jid_esc_outbuf.sv
design/jid_node_escaper_unit.sv
tb/jid_node_escaper_unit_tb.sv
